// ===== src/tcp_address_option_extractor_assert.svh =====
// Assertion macros shared by the option extractor RTL.
// Included by the modules that check their own logic; no other dependency.
`ifndef TCP_ADDRESS_OPTION_EXTRACTOR_ASSERT_SVH
`define TCP_ADDRESS_OPTION_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check an expression on every clock edge outside reset.
`define TAE_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition implies a consequence on the same edge.
`define TAE_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define TAE_ASSERT(name, clk, rstn, prop, msg)
`define TAE_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/tae_pkg.sv =====
// Types and constants of the TCP address option extractor.
// No dependencies; used by every module of the block.
package tae_pkg;

  localparam int MaxOptionBytes = 40;
  localparam int QueueDepth     = 4;
  localparam int QPtrW          = $clog2(QueueDepth);
  localparam int QCntW          = $clog2(QueueDepth + 1);

  localparam logic [7:0] OptEol      = 8'd0;
  localparam logic [7:0] OptNop      = 8'd1;
  localparam logic [7:0] OptHdrBytes = 8'd2;

  localparam logic [1:0] CfgAddrKind = 2'd0;
  localparam logic [1:0] CfgV4Len    = 2'd1;
  localparam logic [1:0] CfgV6Len    = 2'd2;

  localparam logic [7:0] RstAddrKind = 8'd254;
  localparam logic [5:0] RstV4Len    = 6'd8;
  localparam logic [5:0] RstV6Len    = 6'd20;

  typedef enum logic [4:0] {
    PhKind = 5'b00001,
    PhLen  = 5'b00010,
    PhSkip = 5'b00100,
    PhCap  = 5'b01000,
    PhIdle = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    FormNone = 2'd0,
    FormV4   = 2'd1,
    FormV6   = 2'd2
  } form_e;

  typedef enum logic [2:0] {
    VrdNotFound = 3'd0,
    VrdEol      = 3'd1,
    VrdBadLen   = 3'd2,
    VrdPartial  = 3'd3,
    VrdFoundV4  = 3'd4,
    VrdFoundV6  = 3'd5
  } verdict_e;

  // One queue entry: what a single option byte produced.
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay;
    logic       has_vrd;
    logic [2:0] vrd;
    logic       nat64;
    logic       mapped;
  } entry_t;

endpackage

// ===== src/tcp_address_option_extractor.sv =====
// TCP address option extractor: one option byte per beat in, payload/verdict beats out.
// Throughput: one byte per cycle while the queue has room; a byte with two results gives two output beats.
// The output register drains one beat per cycle while out_ready_i is high; a four-entry queue absorbs bursts.
// Reset (rst_ni low, asynchronous): no packet open, queue empty, config at defaults.
// Depends on tae_pkg, tae_front, tae_fifo and tae_back.
module tcp_address_option_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] opt_byte_i,
  input  logic       first_of_packet_i,
  input  logic [5:0] options_len_i,
  input  logic       family_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [2:0] verdict_o,
  output logic       nat64_flag_o,
  output logic       mapped_v4_flag_o,
  output logic       last_of_packet_o
);

  logic            in_acc;
  logic            push, pop, empty, full;
  tae_pkg::entry_t push_ent, head_ent;

  // Config writes are registered directly; the port never stalls.
  assign cfg_ready_o = 1'b1;

  // Take a byte whenever the queue has room, regardless of the output side.
  assign in_ready_o = !full;
  assign in_acc     = in_valid_i & in_ready_o;

  // Parse each accepted byte and build at most one queue entry for it.
  tae_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .acc_i             (in_acc),
    .opt_byte_i        (opt_byte_i),
    .first_of_packet_i (first_of_packet_i),
    .options_len_i     (options_len_i),
    .family_i          (family_i),
    .push_o            (push),
    .ent_o             (push_ent)
  );

  // Decouple parser and output so each can stall on its own.
  tae_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_ent),
    .pop_i   (pop),
    .rdata_o (head_ent),
    .empty_o (empty),
    .full_o  (full)
  );

  // Expand each entry into its payload beat and/or verdict beat.
  tae_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ent_i            (head_ent),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .payload_byte_o   (payload_byte_o),
    .verdict_o        (verdict_o),
    .nat64_flag_o     (nat64_flag_o),
    .mapped_v4_flag_o (mapped_v4_flag_o),
    .last_of_packet_o (last_of_packet_o)
  );

endmodule

// ===== src/tae_front.sv =====
// Front end: accepts option bytes, runs the option parser, pushes result entries.
// Depends on tae_pkg and the assertion header.
`include "tcp_address_option_extractor_assert.svh"
module tae_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              acc_i,
  input  logic [7:0]        opt_byte_i,
  input  logic              first_of_packet_i,
  input  logic [5:0]        options_len_i,
  input  logic              family_i,
  output logic              push_o,
  output tae_pkg::entry_t   ent_o
);

  logic [7:0] addr_kind_q;
  logic [5:0] v4_len_q, v6_len_q;

  logic [5:0]          bl_q, bl_d;
  tae_pkg::phase_e     phase_q, phase_d;
  logic [7:0]          kind_q, kind_d;
  logic [5:0]          skip_q, skip_d;
  logic [5:0]          cap_q, cap_d;
  tae_pkg::form_e      form_q, form_d;
  logic                given_q, given_d;

  logic [5:0]          sat_len;
  logic [5:0]          avail;
  logic [5:0]          body;
  tae_pkg::phase_e     cur_phase;
  tae_pkg::form_e      hit_form;
  tae_pkg::entry_t     ent;

  assign sat_len = (options_len_i > 6'(tae_pkg::MaxOptionBytes)) ?
                   6'(tae_pkg::MaxOptionBytes) : options_len_i;
  assign body    = 6'(opt_byte_i - tae_pkg::OptHdrBytes);

  always_comb begin
    bl_d      = bl_q;
    phase_d   = phase_q;
    kind_d    = kind_q;
    skip_d    = skip_q;
    cap_d     = cap_q;
    form_d    = form_q;
    given_d   = given_q;
    ent       = '0;
    avail     = '0;
    hit_form  = tae_pkg::FormNone;

    // Open a new packet; drop whatever was still in progress.
    if (first_of_packet_i) begin
      given_d = 1'b0;
      form_d  = tae_pkg::FormNone;
      skip_d  = '0;
      cap_d   = '0;
      kind_d  = '0;
      bl_d    = sat_len;
      if (sat_len == '0) begin
        ent.has_vrd = 1'b1;
        ent.vrd     = tae_pkg::VrdNotFound;
        phase_d     = tae_pkg::PhIdle;
      end else begin
        phase_d = tae_pkg::PhKind;
      end
    end

    cur_phase = phase_d;
    if (!ent.has_vrd && cur_phase != tae_pkg::PhIdle && bl_d != '0) begin
      avail   = bl_d;
      bl_d    = bl_d - 6'd1;
      unique case (cur_phase)
        tae_pkg::PhKind: begin
          if (opt_byte_i == tae_pkg::OptEol) begin
            ent.has_vrd = 1'b1;
            ent.vrd     = tae_pkg::VrdEol;
          end else if (opt_byte_i != tae_pkg::OptNop) begin
            if (avail < 6'(tae_pkg::OptHdrBytes)) begin
              ent.has_vrd = 1'b1;
              ent.vrd     = tae_pkg::VrdPartial;
            end else begin
              kind_d  = opt_byte_i;
              phase_d = tae_pkg::PhLen;
            end
          end
        end
        tae_pkg::PhLen: begin
          if (opt_byte_i < tae_pkg::OptHdrBytes) begin
            ent.has_vrd = 1'b1;
            ent.vrd     = tae_pkg::VrdBadLen;
          end else if (9'(opt_byte_i) > 9'(avail) + 9'd1) begin
            ent.has_vrd = 1'b1;
            ent.vrd     = tae_pkg::VrdPartial;
          end else begin
            if (kind_q == addr_kind_q) begin
              if (opt_byte_i == {2'b00, v4_len_q}) begin
                hit_form = tae_pkg::FormV4;
              end else if (opt_byte_i == {2'b00, v6_len_q}) begin
                hit_form = tae_pkg::FormV6;
              end
            end
            form_d = hit_form;
            if (hit_form != tae_pkg::FormNone) begin
              if (body == '0) begin
                ent.has_vrd = 1'b1;
              end else begin
                cap_d   = body;
                phase_d = tae_pkg::PhCap;
              end
            end else if (body == '0) begin
              phase_d = tae_pkg::PhKind;
            end else begin
              skip_d  = body;
              phase_d = tae_pkg::PhSkip;
            end
          end
        end
        tae_pkg::PhSkip: begin
          if (skip_q != '0) skip_d = skip_q - 6'd1;
          if (skip_d == '0) phase_d = tae_pkg::PhKind;
        end
        tae_pkg::PhCap: begin
          ent.has_pay = 1'b1;
          ent.pay     = opt_byte_i;
          if (cap_q != '0) cap_d = cap_q - 6'd1;
          if (cap_d == '0) begin
            hit_form    = form_q;
            ent.has_vrd = 1'b1;
          end
        end
        default: begin
          phase_d = tae_pkg::PhIdle;
        end
      endcase

      // Found verdict: report the matched form and the family flags.
      if (ent.has_vrd && hit_form != tae_pkg::FormNone) begin
        if (hit_form == tae_pkg::FormV6) begin
          ent.vrd   = tae_pkg::VrdFoundV6;
          ent.nat64 = ~family_i;
        end else begin
          ent.vrd    = tae_pkg::VrdFoundV4;
          ent.mapped = family_i;
        end
      end

      // Area exhausted with nothing decided.
      if (!ent.has_vrd && bl_d == '0 && !given_d) begin
        ent.has_vrd = 1'b1;
        ent.vrd     = tae_pkg::VrdNotFound;
      end
    end

    if (ent.has_vrd) begin
      given_d = 1'b1;
      phase_d = tae_pkg::PhIdle;
    end
  end

  assign push_o = acc_i & (ent.has_pay | ent.has_vrd);
  assign ent_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_kind_q <= tae_pkg::RstAddrKind;
      v4_len_q    <= tae_pkg::RstV4Len;
      v6_len_q    <= tae_pkg::RstV6Len;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tae_pkg::CfgAddrKind: addr_kind_q <= cfg_data_i;
        tae_pkg::CfgV4Len:    v4_len_q    <= cfg_data_i[5:0];
        tae_pkg::CfgV6Len:    v6_len_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q    <= '0;
      phase_q <= tae_pkg::PhIdle;
      kind_q  <= '0;
      skip_q  <= '0;
      cap_q   <= '0;
      form_q  <= tae_pkg::FormNone;
      given_q <= 1'b0;
    end else if (acc_i) begin
      bl_q    <= bl_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
      skip_q  <= skip_d;
      cap_q   <= cap_d;
      form_q  <= form_d;
      given_q <= given_d;
    end
  end

  `TAE_ASSERT_IMP(a_given_idle, clk_i, rst_ni, given_q, phase_q == tae_pkg::PhIdle, "open parse")
  `TAE_ASSERT_IMP(a_skip_nonzero, clk_i, rst_ni, phase_q == tae_pkg::PhSkip, skip_q != '0, "skip 0")

endmodule

// ===== src/tae_fifo.sv =====
// Short queue of result entries between the parser front and the output back end.
// Depends on tae_pkg and the assertion header.
`include "tcp_address_option_extractor_assert.svh"
module tae_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tae_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output tae_pkg::entry_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);

  tae_pkg::entry_t               mem_q [tae_pkg::QueueDepth];
  logic [tae_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [tae_pkg::QCntW-1:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == tae_pkg::QCntW'(tae_pkg::QueueDepth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + tae_pkg::QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + tae_pkg::QPtrW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + tae_pkg::QCntW'(1);
        2'b01:   cnt_q <= cnt_q - tae_pkg::QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `TAE_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o && !pop_i), "push into full queue")
  `TAE_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")

endmodule

// ===== src/tae_back.sv =====
// Back end: drains queue entries into an output register, one beat per cycle while the output is ready.
// Depends on tae_pkg and the assertion header.
`include "tcp_address_option_extractor_assert.svh"
module tae_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tae_pkg::entry_t ent_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [2:0]      verdict_o,
  output logic            nat64_flag_o,
  output logic            mapped_v4_flag_o,
  output logic            last_of_packet_o
);

  logic       valid_q;
  logic       pend_q;
  logic [2:0] pend_vrd_q;
  logic       pend_nat_q, pend_map_q;
  logic       kind_q;
  logic [7:0] pay_q;
  logic [2:0] vrd_q;
  logic       nat_q, map_q;
  logic       load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (!empty_i) begin
        valid_q <= 1'b1;
        pend_q  <= ent_i.has_pay & ent_i.has_vrd;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload byte goes out first; hold the verdict of the same entry for the next beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        kind_q <= 1'b1;
        pay_q  <= '0;
        vrd_q  <= pend_vrd_q;
        nat_q  <= pend_nat_q;
        map_q  <= pend_map_q;
      end else if (!empty_i) begin
        pend_vrd_q <= ent_i.vrd;
        pend_nat_q <= ent_i.nat64;
        pend_map_q <= ent_i.mapped;
        if (ent_i.has_pay) begin
          kind_q <= 1'b0;
          pay_q  <= ent_i.pay;
          vrd_q  <= tae_pkg::VrdNotFound;
          nat_q  <= 1'b0;
          map_q  <= 1'b0;
        end else begin
          kind_q <= 1'b1;
          pay_q  <= '0;
          vrd_q  <= ent_i.vrd;
          nat_q  <= ent_i.nat64;
          map_q  <= ent_i.mapped;
        end
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign out_kind_o       = kind_q;
  assign payload_byte_o   = pay_q;
  assign verdict_o        = vrd_q;
  assign nat64_flag_o     = nat_q;
  assign mapped_v4_flag_o = map_q;
  assign last_of_packet_o = kind_q;

  `TAE_ASSERT_IMP(a_pend_after_payload, clk_i, rst_ni, pend_q, valid_q && !kind_q, "pending verdict without payload beat in front of it")

endmodule
